### hdl/escgcr_pkg.sv
package escgcr_pkg;

  // Number of motor channels that have a record
  localparam int CHANNELS = 8;
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Divider: 600000 / period, period = 9-bit mantissa << odd exponent (max 7)
  localparam int DIVIDEND_W = 20;
  localparam int PERIOD_W   = 17;
  localparam int QUOT_W     = DIVIDEND_W;
  localparam logic [DIVIDEND_W-1:0] DIVIDEND = DIVIDEND_W'(600000);
  localparam logic [15:0] SPEED_MAX = 16'hffff;

  typedef logic [PERIOD_W-1:0] period_t;
  typedef logic [QUOT_W-1:0]   quot_t;

  typedef enum logic [2:0] {
    ST_EDT     = 3'd0,
    ST_ERPM    = 3'd1,
    ST_BADCODE = 3'd2,
    ST_CRC     = 3'd3,
    ST_IGNORED = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_DIV,
    S_OUT
  } state_t;

  // GCR 5-bit group -> {valid, nibble}
  function automatic logic [4:0] nib_lookup(input logic [4:0] grp);
    logic [4:0] r;
    case (grp)
      5'd9:    r = {1'b1, 4'd9};
      5'd10:   r = {1'b1, 4'd10};
      5'd11:   r = {1'b1, 4'd11};
      5'd13:   r = {1'b1, 4'd13};
      5'd14:   r = {1'b1, 4'd14};
      5'd15:   r = {1'b1, 4'd15};
      5'd18:   r = {1'b1, 4'd2};
      5'd19:   r = {1'b1, 4'd3};
      5'd21:   r = {1'b1, 4'd5};
      5'd22:   r = {1'b1, 4'd6};
      5'd23:   r = {1'b1, 4'd7};
      5'd25:   r = {1'b1, 4'd0};
      5'd26:   r = {1'b1, 4'd8};
      5'd27:   r = {1'b1, 4'd1};
      5'd29:   r = {1'b1, 4'd4};
      5'd30:   r = {1'b1, 4'd12};
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

### hdl/esc_telemetry_gcr_decoder.sv
// Channel  Handshake                    Payload
// item     item_valid / item_stall      channel, raw_word, capture_time
// result   result_valid / result_stall  result_channel, status, ext_type,
//                                       ext_value, erpm_value, record_time
//
// One item at a time. Accept, a decode step, then the result register.
// eRPM updates pass through the bit-serial divider (600000 / period) before the
// result register; all other outcomes load it straight from the decode step.
// rst (synchronous) clears the sequencer and all channel records.
// item_stall is high from accept until the result item is taken; a stalled
// result holds its payload.
module esc_telemetry_gcr_decoder (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  logic [3:0]           channel,
  input  logic [20:0]          raw_word,
  input  logic [31:0]          capture_time,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic [3:0]           result_channel,
  output escgcr_pkg::status_t  status,
  output logic [3:0]           ext_type,
  output logic [7:0]           ext_value,
  output logic [15:0]          erpm_value,
  output logic [31:0]          record_time
);
  import escgcr_pkg::*;

  state_t state;
  state_t state_next;

  // Latched item
  logic [3:0]  lat_ch;
  logic [20:0] lat_raw;
  logic [31:0] lat_time;

  // Per-channel records
  logic [3:0]  type_store  [CHANNELS];
  logic [7:0]  value_store [CHANNELS];
  logic [15:0] speed_store [CHANNELS];
  logic [31:0] time_store  [CHANNELS];

  // Decode path
  logic [19:0]         gcr;
  logic [15:0]         pkt;
  logic                bad;
  logic [4:0]          ent;
  logic [3:0]          crc_x;
  logic                crc_ok;
  logic [11:0]         pay;
  logic [2:0]          expo;
  logic [8:0]          mant;
  logic                ch_ok;
  logic [CH_IDX_W-1:0] idx;
  period_t             period;
  status_t             dec_status;
  logic                start_div;
  logic                div_done;
  quot_t               quotient;
  logic [15:0]         speed_sat;

  wire accept_in  = item_valid && !item_stall;
  wire accept_out = result_valid && !result_stall;

  assign item_stall = (state != S_IDLE);

  // Undo transition coding, map groups low first, check inverted checksum
  always_comb begin
    gcr = lat_raw[19:0] ^ lat_raw[20:1];
    bad = 1'b0;
    pkt = '0;
    ent = '0;
    for (int i = 0; i < 4; i++) begin
      ent = nib_lookup(gcr[5*i +: 5]);
      bad = bad | ~ent[4];
      pkt[4*i +: 4] = ent[3:0];
    end
    crc_x  = pkt[7:4] ^ pkt[11:8] ^ pkt[15:12];
    crc_ok = (~crc_x == pkt[3:0]);
    pay    = pkt[15:4];
    expo   = pay[11:9];
    mant   = pay[8:0];
    period = period_t'({8'd0, mant} << expo);
    ch_ok  = ({1'b0, lat_ch} < 5'(CHANNELS));
    idx    = lat_ch[CH_IDX_W-1:0];
  end

  // Outcome of the decode cycle
  always_comb begin
    dec_status = ST_IGNORED;
    start_div  = 1'b0;
    if (!ch_ok) begin
      dec_status = ST_IGNORED;
    end else if (bad) begin
      dec_status = ST_BADCODE;
    end else if (!crc_ok) begin
      dec_status = ST_CRC;
    end else if (pay == 12'd0) begin
      dec_status = ST_IGNORED;
    end else if (!expo[0]) begin
      dec_status = ST_EDT;
    end else if (mant == 9'd0) begin
      dec_status = ST_IGNORED;
    end else begin
      dec_status = ST_ERPM;
      start_div  = (state == S_DECODE);
    end
  end

  escgcr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (start_div),
    .divisor  (period),
    .done     (div_done),
    .quotient (quotient)
  );

  // Saturate eRPM/100 to 16 bits
  assign speed_sat = (quotient[QUOT_W-1:16] != '0) ? SPEED_MAX : quotient[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept_in) state_next = S_DECODE;
      end
      S_DECODE: begin
        state_next = start_div ? S_DIV : S_OUT;
      end
      S_DIV: begin
        if (div_done) state_next = S_OUT;
      end
      S_OUT: begin
        if (accept_out) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign result_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (accept_in) begin
      lat_ch   <= channel;
      lat_raw  <= raw_word;
      lat_time <= capture_time;
    end
  end

  // Records: cleared by reset, written on an accepted update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        type_store[c]  <= '0;
        value_store[c] <= '0;
        speed_store[c] <= '0;
        time_store[c]  <= '0;
      end
    end else if (state == S_DECODE && ch_ok && dec_status == ST_EDT) begin
      type_store[idx]  <= pay[11:8];
      value_store[idx] <= pay[7:0];
      time_store[idx]  <= lat_time;
    end else if (state == S_DIV && div_done) begin
      speed_store[idx] <= speed_sat;
      time_store[idx]  <= lat_time;
    end
  end

  // Result register, loaded with the record as it stands after the update (zeros for an out-of-range channel)
  always_ff @(posedge clk) begin
    if (state == S_DECODE && !start_div) begin
      result_channel <= lat_ch;
      status         <= dec_status;
      if (!ch_ok) begin
        ext_type    <= '0;
        ext_value   <= '0;
        erpm_value  <= '0;
        record_time <= '0;
      end else if (dec_status == ST_EDT) begin
        ext_type    <= pay[11:8];
        ext_value   <= pay[7:0];
        erpm_value  <= speed_store[idx];
        record_time <= lat_time;
      end else begin
        ext_type    <= type_store[idx];
        ext_value   <= value_store[idx];
        erpm_value  <= speed_store[idx];
        record_time <= time_store[idx];
      end
    end else if (state == S_DIV && div_done) begin
      result_channel <= lat_ch;
      status         <= ST_ERPM;
      ext_type       <= type_store[idx];
      ext_value      <= value_store[idx];
      erpm_value     <= speed_sat;
      record_time    <= lat_time;
    end
  end

endmodule

### hdl/escgcr_div.sv
module escgcr_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  escgcr_pkg::period_t divisor,
  output logic                done,
  output escgcr_pkg::quot_t   quotient
);
  import escgcr_pkg::*;

  // Restoring divider of the fixed dividend, one quotient bit per cycle
  logic                      busy;
  logic [$clog2(QUOT_W)-1:0] cnt;
  logic [PERIOD_W-1:0]       rem;
  logic [PERIOD_W-1:0]       rem_next;
  logic [QUOT_W-1:0]         quo;
  logic [QUOT_W-1:0]         quo_next;
  logic [PERIOD_W-1:0]       dvs;
  logic [PERIOD_W:0]         shifted;
  logic [PERIOD_W:0]         diff;
  logic                      ge;

  always_comb begin
    shifted  = {rem, quo[QUOT_W-1]};
    ge       = (shifted >= {1'b0, dvs});
    diff     = shifted - {1'b0, dvs};
    rem_next = ge ? diff[PERIOD_W-1:0] : shifted[PERIOD_W-1:0];
    quo_next = {quo[QUOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == ($clog2(QUOT_W))'(QUOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= DIVIDEND;
      dvs <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign quotient = quo;

endmodule
